>>> design/sine_square_tone_generator_defines.svh
// Assertion macros shared by the tone generator RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef SINE_SQUARE_TONE_GENERATOR_DEFINES_SVH
`define SINE_SQUARE_TONE_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define SSTG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SSTG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SSTG_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define SSTG_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/sstg_pkg.sv
`timescale 1ns / 1ps

package sstg_pkg;

   // CORDIC iteration count and phase bits used for the sine
   localparam int CORDIC_STEPS = 18;
   localparam int PHASE_BITS   = 32;

   // arctangent table length and index width
   localparam int TABLE_LEN   = 30;
   localparam int TBL_IDX_W   = $clog2(TABLE_LEN);
   localparam int STEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   // datapath widths
   localparam int PHASE_W = 32;
   localparam int XY_W    = 34;
   localparam int Z_W     = 33;
   localparam int SINE_W  = 32;
   localparam int MAG_W   = 31;
   localparam int AMP_W   = 17;
   localparam int BITS_W  = 6;
   localparam int PROD_W  = MAG_W + AMP_W;
   localparam int SAMPLE_W = 32;

   // Q2.30 constants
   localparam logic signed [XY_W-1:0] SIN_ONE   = XY_W'(64'sd1073741824);
   localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(64'sd652032874);
   localparam logic [MAG_W-1:0]       DEADBAND  = MAG_W'(64'd10737418);
   localparam logic [MAG_W-1:0]       MAG_ONE   = MAG_W'(64'd1073741824);

   // keep mask for the top PHASE_BITS bits of the accumulator
   localparam logic [PHASE_W-1:0] PHASE_KEEP =
      ~((PHASE_W'(1) << (PHASE_W - PHASE_BITS)) - PHASE_W'(1));

   // configuration limits
   localparam logic [AMP_W-1:0]  AMP_FULL  = AMP_W'(65536);
   localparam logic [BITS_W-1:0] BITS_MIN  = BITS_W'(8);
   localparam logic [BITS_W-1:0] BITS_MAX  = BITS_W'(32);
   localparam logic [BITS_W-1:0] BITS_RST  = BITS_W'(16);

   // register indexes on the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BITS       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SHAPE = CSR_IDX_W'(3);

   // wave shape codes
   localparam logic WAVE_SINE   = 1'b0;
   localparam logic WAVE_SQUARE = 1'b1;

   // arctangent of 2^-i as a turn fraction times 2^32
   localparam logic [29:0] ATAN_TURNS [TABLE_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
      30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
      30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
      30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   // output scaling settings seen by the sample former
   typedef struct packed {
      logic [AMP_W-1:0]  amplitude;
      logic [BITS_W-1:0] bits_per_sample;
      logic              wave_shape;
   } scale_cfg_type;

   // CORDIC result towards the sequencer
   typedef struct packed {
      logic                     done;
      logic signed [SINE_W-1:0] sine;
   } cordic_status_type;

endpackage

>>> design/sine_square_tone_generator.sv
// Tone generator by direct digital synthesis. Each request on req_ (with
// req_restart set to clear the phase first) yields exactly one signed sample
// on rsp_. The sine of the 32-bit phase accumulator is found by an iterative
// CORDIC that runs one rotation per cycle through a single shift-and-add
// unit. The CORDIC is loaded at the accepting edge itself. From acceptance a
// request passes the rotations, a clamp step, a multiply step and a step
// that forms and saturates the sample into the output register; that last
// step waits while the output register still holds an untaken sample.
// req_stall stays high from acceptance until the sample has moved into the
// output register; no request is taken meanwhile. The output register lets
// the next request be taken while a sample still waits; a second sample
// then holds in the form step, with req_stall high, until the first is taken.
// Registers on csr_: 0 phase step, 1 amplitude (Q1.16), 2 bits per sample,
// 3 wave shape (0 sine, 1 square with deadband); write them only while idle.
`timescale 1ns / 1ps
`include "sine_square_tone_generator_defines.svh"

module sine_square_tone_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [sstg_pkg::SAMPLE_W-1:0] rsp_sample,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sstg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import sstg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ROTATE = 3'b010,
      ST_FORM   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [PHASE_W-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_W-1:0] phase_step_ff, phase_step_in;
   logic [AMP_W-1:0]   amplitude_ff, amplitude_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic               wave_ff, wave_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic               req_take;
   logic               out_free;
   logic               out_load;
   logic [PHASE_W-1:0] phase_now;
   cordic_status_type  cs;
   scale_cfg_type      scfg;
   logic [SAMPLE_W-1:0] sample;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_FORM) && out_free;
   assign phase_now = req_restart ? '0 : phase_acc_ff;

   assign scfg.amplitude       = amplitude_ff;
   assign scfg.bits_per_sample = bits_ff;
   assign scfg.wave_shape      = wave_ff;

   sstg_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (req_take),
      .phase  (phase_now),
      .status (cs)
   );

   sstg_scale u_scale (
      .clock  (clock),
      .load   (cs.done),
      .sine   (cs.sine),
      .cfg    (scfg),
      .sample (sample)
   );

   // decode register writes
   always_comb begin
      phase_step_in = phase_step_ff;
      amplitude_in  = amplitude_ff;
      bits_in       = bits_ff;
      wave_in       = wave_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PHASE_STEP: phase_step_in = csr_wdata;
            CSR_AMPLITUDE:  amplitude_in  = csr_wdata[AMP_W-1:0];
            CSR_BITS:       bits_in       = csr_wdata[BITS_W-1:0];
            CSR_WAVE_SHAPE: wave_in       = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequence one request through rotate and form
   always_comb begin
      state_in     = state_ff;
      phase_acc_in = phase_acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               phase_acc_in = phase_now + phase_step_ff;
               state_in     = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            if (cs.done) begin
               state_in = ST_FORM;
            end
         end
         ST_FORM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the sample until the far side takes it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = sample;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_acc_ff  <= '0;
         phase_step_ff <= '0;
         amplitude_ff  <= AMP_FULL;
         bits_ff       <= BITS_RST;
         wave_ff       <= WAVE_SINE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_acc_ff  <= phase_acc_in;
         phase_step_ff <= phase_step_in;
         amplitude_ff  <= amplitude_in;
         bits_ff       <= bits_in;
         wave_ff       <= wave_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = $signed(rsp_sample_ff);

   // checks on the sequencer and the CORDIC hand-off
   `SSTG_ASSERT_NXT(a_busy_after_req, clock, reset, req_take, req_stall)
   `SSTG_ASSERT_IMP(a_done_in_rotate, clock, reset, cs.done, state_ff == ST_ROTATE)
   `SSTG_ASSERT_IMP(a_sine_in_range, clock, reset, cs.done,
      (cs.sine <= SINE_W'(SIN_ONE)) && (cs.sine >= SINE_W'(-SIN_ONE)))
   `SSTG_ASSERT_IMP(a_rsp_from_form, clock, reset, rsp_valid && !$past(rsp_valid), $past(state_ff == ST_FORM))

endmodule

>>> design/sstg_cordic.sv
`timescale 1ns / 1ps

module sstg_cordic (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sstg_pkg::PHASE_W-1:0] phase,
   output sstg_pkg::cordic_status_type  status
);
   import sstg_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   fin_ff, fin_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]             quad_ff, quad_in;
   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in;
   logic signed [SINE_W-1:0] sine_ff, sine_in;

   logic [PHASE_W-1:0]     phase_kept;
   logic signed [XY_W-1:0] dx, dy, sel;
   logic signed [Z_W-1:0]  at;
   logic                   last_step;

   assign phase_kept = phase & PHASE_KEEP;
   assign last_step  = (cnt_ff == STEP_W'(CORDIC_STEPS - 1));

   // shared shift and add unit: one rotation per cycle
   assign dx = y_ff >>> cnt_ff;
   assign dy = x_ff >>> cnt_ff;
   assign at = $signed({{(Z_W - 30){1'b0}}, ATAN_TURNS[TBL_IDX_W'(cnt_ff)]});

   // pick the quadrant output from the final vector
   always_comb begin
      case (quad_ff)
         2'd0:    sel = y_ff;
         2'd1:    sel = x_ff;
         2'd2:    sel = -y_ff;
         default: sel = -x_ff;
      endcase
   end

   // sequence load, rotate, finish
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      sine_in = sine_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quad_in = phase_kept[PHASE_W-1 -: 2];
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = $signed({{(Z_W - 30){1'b0}}, phase_kept[29:0]});
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      // clamp to plus or minus one and hold
      if (fin_ff) begin
         done_in = 1'b1;
         if (sel > SIN_ONE) begin
            sine_in = SINE_W'(SIN_ONE);
         end else if (sel < -SIN_ONE) begin
            sine_in = SINE_W'(-SIN_ONE);
         end else begin
            sine_in = SINE_W'(sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sine_ff <= sine_in;
   end

   assign status.done = done_ff;
   assign status.sine = sine_ff;

endmodule

>>> design/sstg_scale.sv
`timescale 1ns / 1ps

module sstg_scale (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [sstg_pkg::SINE_W-1:0] sine,
   input  sstg_pkg::scale_cfg_type            cfg,
   output logic [sstg_pkg::SAMPLE_W-1:0]      sample
);
   import sstg_pkg::*;

   logic [PROD_W-1:0] product_ff, product_in;
   logic              neg_ff, neg_in;

   logic [MAG_W-1:0]  mag;
   logic [MAG_W-1:0]  mult_a;
   logic [AMP_W-1:0]  amp_eff;
   logic [BITS_W-1:0] bits_eff;
   logic [BITS_W-1:0] shamt;
   logic [PROD_W-1:0] shifted;
   logic [32:0]       mag_out;
   logic [32:0]       lim;
   logic [32:0]       res;

   // clamp the settings to their working ranges
   always_comb begin
      amp_eff = (cfg.amplitude > AMP_FULL) ? AMP_FULL : cfg.amplitude;
      if (cfg.bits_per_sample < BITS_MIN) begin
         bits_eff = BITS_MIN;
      end else if (cfg.bits_per_sample > BITS_MAX) begin
         bits_eff = BITS_MAX;
      end else begin
         bits_eff = cfg.bits_per_sample;
      end
   end

   // magnitude of the sine; square mode uses full scale outside the deadband
   always_comb begin
      neg_in = sine < 0;
      mag    = MAG_W'(neg_in ? -sine : sine);
      if (cfg.wave_shape == WAVE_SQUARE) begin
         mult_a = (mag <= DEADBAND) ? '0 : MAG_ONE;
      end else begin
         mult_a = mag;
      end
      product_in = PROD_W'(mult_a) * PROD_W'(amp_eff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
         neg_ff     <= neg_in;
      end
   end

   // drop fraction bits, apply the sign and saturate to the sample width
   always_comb begin
      shamt   = BITS_W'(47) - bits_eff;
      shifted = product_ff >> shamt;
      mag_out = shifted[32:0];
      lim     = 33'd1 << (bits_eff - BITS_W'(1));
      if (neg_ff) begin
         res = (mag_out > lim) ? -lim : -mag_out;
      end else begin
         res = (mag_out >= lim) ? lim - 33'd1 : mag_out;
      end
      sample = res[SAMPLE_W-1:0];
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDX_W = sstg_pkg::CSR_IDX_W;

   // first index past the last defined register
   localparam logic [IDX_W-1:0] CSR_FIRST_UNUSED = sstg_pkg::CSR_WAVE_SHAPE + 1'b1;

   // Q2.30 sine arithmetic
   localparam longint SINE_ONE_Q30   = 64'sd1073741824;
   localparam longint GAIN_INV_Q30   = 64'sd652032874;
   localparam longint DEADBAND_Q30   = 64'sd10737418;
   localparam longint FULL_SCALE_AMP = 64'sd65536;
   localparam int     ATAN_ENTRIES   = 30;
   localparam int     MIN_WIDTH      = 8;
   localparam int     MAX_WIDTH      = 32;

   // arctangent of 2^-i as turn fraction times 2^32
   localparam longint ATAN_TURN [ATAN_ENTRIES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81,
      41, 20, 10, 5, 3, 1
   };

   localparam logic [31:0] PHASE_MASK =
      ~((32'd1 << (32 - sstg_pkg::PHASE_BITS)) - 32'd1);

   localparam int SETTLE_CYCLES  = sstg_pkg::CORDIC_STEPS + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 16;
   localparam int TICKS_PER_PHASE = 90;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_restart;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [sstg_pkg::SAMPLE_W-1:0] rsp_sample;
   logic csr_valid;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   // shadow of the tone state and registers
   logic [31:0] tone_phase;
   logic [31:0] step_cfg;
   logic [16:0] amp_cfg;
   logic [5:0]  width_cfg;
   logic        shape_cfg;

   logic signed [31:0] expected_samples [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   bit no_idle = 1'b0;

   sine_square_tone_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // sine of the phase by CORDIC in Q2.30, clamped to +-1.0
   function automatic longint sine_of_phase(input logic [31:0] phase);
      logic [31:0] p;
      longint x, y, z, dx, dy, s;
      p = phase & PHASE_MASK;
      x = GAIN_INV_Q30;
      y = 0;
      z = longint'(p[29:0]);
      for (int i = 0; i < sstg_pkg::CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURN[i];
         end
      end
      case (p[31:30])
         2'd0: s = y;
         2'd1: s = x;
         2'd2: s = -y;
         default: s = -x;
      endcase
      if (s > SINE_ONE_Q30) s = SINE_ONE_Q30;
      if (s < -SINE_ONE_Q30) s = -SINE_ONE_Q30;
      return s;
   endfunction

   // form the sample for one tick and advance the phase
   function automatic logic signed [31:0] next_tone_sample(input logic restart);
      longint s, mag, amp, top, res;
      int width;
      bit neg;
      width = int'(width_cfg);
      if (width < MIN_WIDTH) width = MIN_WIDTH;
      if (width > MAX_WIDTH) width = MAX_WIDTH;
      amp = (longint'(amp_cfg) > FULL_SCALE_AMP) ? FULL_SCALE_AMP : longint'(amp_cfg);
      if (restart) tone_phase = '0;
      s = sine_of_phase(tone_phase);
      neg = (s < 0);
      mag = neg ? -s : s;
      if (shape_cfg == sstg_pkg::WAVE_SINE) begin
         mag = (mag * amp) >> (47 - width);
      end else if (mag <= DEADBAND_Q30) begin
         mag = 0;
      end else begin
         mag = (amp << (width - 1)) >> 16;
      end
      top = (longint'(1) << (width - 1)) - 1;
      res = neg ? -mag : mag;
      if (res > top) res = top;
      if (res < -top - 1) res = -top - 1;
      tone_phase = tone_phase + step_cfg;
      return res[31:0];
   endfunction

   // predict on each accepted request, check each accepted sample
   always @(posedge clock) begin : sample_checker
      logic signed [31:0] want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_samples.push_back(next_tone_sample(req_restart));
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("rsp_sample %0d arrived with no request outstanding", rsp_sample);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want) begin
                  $error("rsp_sample mismatch: expected %0d, actual %0d", want, rsp_sample);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stall the sample channel a random number of cycles per sample
   always begin : rsp_backpressure
      int hold;
      @(negedge clock);
      hold = no_idle ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
         rsp_stall = 1'b1;
         repeat (hold) @(negedge clock);
      end
      rsp_stall = 1'b0;
      do @(posedge clock); while (reset || rsp_valid !== 1'b1);
   end

   // end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // send one tick request; valid stays high for a back-to-back follower
   task automatic send_tick(input logic restart);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_restart = restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // write one register and mirror it in the shadow copy
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sstg_pkg::CSR_PHASE_STEP: step_cfg = data;
         sstg_pkg::CSR_AMPLITUDE:  amp_cfg = data[16:0];
         sstg_pkg::CSR_BITS:       width_cfg = data[5:0];
         sstg_pkg::CSR_WAVE_SHAPE: shape_cfg = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // drop valid, wait for every sample, then let the pipeline empty
   task automatic drain;
      req_valid = 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_defaults;
      send_tick(1'b0);
      send_tick(1'b1);
      drain();
   endtask

   // quarter-turn steps at 32 bits: hits both saturation limits
   task automatic test_quadrants;
      write_reg(sstg_pkg::CSR_PHASE_STEP, 32'h4000_0000);
      write_reg(sstg_pkg::CSR_BITS, 32'd32);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      drain();
   endtask

   // square wave on eighth turns, narrowest sample, amplitude over full scale
   task automatic test_square_octants;
      write_reg(sstg_pkg::CSR_WAVE_SHAPE, {31'd0, sstg_pkg::WAVE_SQUARE});
      write_reg(sstg_pkg::CSR_PHASE_STEP, 32'h2000_0000);
      write_reg(sstg_pkg::CSR_BITS, 32'd8);
      write_reg(sstg_pkg::CSR_AMPLITUDE, 32'h0001_FFFF);
      send_tick(1'b1);
      repeat (7) send_tick(1'b0);
      drain();
   endtask

   // zero amplitude, width below the minimum, largest step
   task automatic test_silent_sine;
      write_reg(sstg_pkg::CSR_WAVE_SHAPE, {31'd0, sstg_pkg::WAVE_SINE});
      write_reg(sstg_pkg::CSR_PHASE_STEP, 32'hFFFF_FFFF);
      write_reg(sstg_pkg::CSR_BITS, 32'd0);
      write_reg(sstg_pkg::CSR_AMPLITUDE, 32'd0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      drain();
   endtask

   // step along inside the square deadband; width above the maximum, unused index
   task automatic test_deadband;
      write_reg(sstg_pkg::CSR_WAVE_SHAPE, {31'd0, sstg_pkg::WAVE_SQUARE});
      write_reg(sstg_pkg::CSR_PHASE_STEP, 32'h0010_0000);
      write_reg(sstg_pkg::CSR_BITS, 32'd63);
      write_reg(sstg_pkg::CSR_AMPLITUDE, 32'd65535);
      write_reg(CSR_FIRST_UNUSED, 32'hFFFF_FFFF);
      send_tick(1'b1);
      repeat (6) send_tick(1'b0);
      drain();
   endtask

   // random settings per phase, random ticks with occasional restarts
   task automatic test_random_tones;
      logic [31:0] noise;
      logic [31:0] step;
      logic [16:0] amp;
      logic [5:0]  width;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         no_idle = (ph % 4 == 3);
         case ($urandom_range(0, 5))
            0: step = 32'd0;
            1: step = 32'hFFFF_FFFF;
            2, 3: step = $urandom_range(1, 1 << 24);
            default: step = $urandom;
         endcase
         write_reg(sstg_pkg::CSR_PHASE_STEP, step);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: amp = 17'd0;
               1: amp = 17'd65536;
               2: amp = 17'($urandom_range(65537, 131071));
               default: amp = 17'($urandom_range(0, 65536));
            endcase
            noise = $urandom;
            write_reg(sstg_pkg::CSR_AMPLITUDE, {noise[31:17], amp});
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 6))
               0: width = 6'($urandom_range(0, 7));
               1: width = 6'($urandom_range(33, 63));
               2: width = 6'd8;
               3: width = 6'd32;
               default: width = 6'($urandom_range(8, 32));
            endcase
            noise = $urandom;
            write_reg(sstg_pkg::CSR_BITS, {noise[31:6], width});
         end
         if ($urandom_range(0, 3) != 0) begin
            noise = $urandom;
            write_reg(sstg_pkg::CSR_WAVE_SHAPE, noise);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(IDX_W'($urandom_range(CSR_FIRST_UNUSED, (1 << IDX_W) - 1)), $urandom);
         for (int n = 0; n < TICKS_PER_PHASE; n++)
            send_tick($urandom_range(0, 15) == 0);
         drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tone_phase = '0;
      step_cfg = '0;
      amp_cfg = 17'd65536;
      width_cfg = 6'd16;
      shape_cfg = sstg_pkg::WAVE_SINE;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_quadrants();
      test_square_octants();
      test_silent_sine();
      test_deadband();
      test_random_tones();

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/sstg_pkg.sv
design/sstg_cordic.sv
design/sstg_scale.sv
design/sine_square_tone_generator.sv
tb/tb_top.sv
